/* rtl/dabd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dabd_pkg;

   localparam int unsigned DEF_MAX_CLASSES = 128;
   localparam int unsigned CLASS_W         = 7;
   localparam int unsigned VALUE_W         = 32;
   localparam int unsigned COORD_W         = 31;
   localparam int unsigned CONF_W          = 17;
   localparam int unsigned NCLS_W          = 8;
   localparam int unsigned FRAME_W         = 15;
   localparam int unsigned CNT_W           = 8;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 15;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CLASSES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic [NCLS_W-1:0]  RST_NUM_CLASSES = 8'd80;
   localparam logic [FRAME_W-1:0] RST_FRAME_SIZE  = 15'd640;

   // opcodes
   localparam logic OP_THRESHOLD = 1'b0;
   localparam logic OP_TENSOR    = 1'b1;

   // attribute positions in a row
   localparam logic [CNT_W-1:0] ATTR_CX    = 8'd0;
   localparam logic [CNT_W-1:0] ATTR_CY    = 8'd1;
   localparam logic [CNT_W-1:0] ATTR_W     = 8'd2;
   localparam logic [CNT_W-1:0] ATTR_H     = 8'd3;
   localparam logic [CNT_W-1:0] ATTR_SCORE = 8'd4;

   localparam logic signed [VALUE_W-1:0] SCORE_ONE = 32'sd65536;

   typedef struct packed {
      logic                      opcode;
      logic [CLASS_W-1:0]        class_index;
      logic signed [VALUE_W-1:0] value;
      logic                      first_of_tensor;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] box_left;
      logic [COORD_W-1:0] box_top;
      logic [COORD_W-1:0] box_span_x;
      logic [COORD_W-1:0] box_span_y;
      logic [CLASS_W-1:0] best_class_id;
      logic [CONF_W-1:0]  confidence;
   } rsp_type;

   // finished row handed to the box pipeline
   typedef struct packed {
      logic signed [VALUE_W-1:0] cx;
      logic signed [VALUE_W-1:0] cy;
      logic signed [VALUE_W-1:0] w;
      logic signed [VALUE_W-1:0] h;
      logic signed [VALUE_W-1:0] best;
      logic [CLASS_W-1:0]        cls;
      logic                      thr_en;
   } row_type;

   // edge from 2*center -/+ size, clamped to [0, 2*lim<<16], halved
   function automatic logic [COORD_W-1:0] clamp_edge(
      input logic signed [VALUE_W-1:0] c,
      input logic signed [VALUE_W-1:0] s,
      input logic                      plus,
      input logic [FRAME_W-1:0]        lim
   );
      logic signed [VALUE_W+1:0] d;
      logic signed [VALUE_W+1:0] hi;
      logic        [VALUE_W-1:0] cl;
      d  = plus ? ((VALUE_W+2)'(c) <<< 1) + (VALUE_W+2)'(s)
                : ((VALUE_W+2)'(c) <<< 1) - (VALUE_W+2)'(s);
      hi = $signed({2'b00, lim, 17'b0});
      if (d < 0) begin
         cl = '0;
      end else if (d > hi) begin
         cl = hi[VALUE_W-1:0];
      end else begin
         cl = d[VALUE_W-1:0];
      end
      return cl[VALUE_W-1:1];
   endfunction

endpackage

`default_nettype wire

/* rtl/dabd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module dabd_ram #(
   parameter int unsigned WIDTH  = 32,
   parameter int unsigned DEPTH  = 128,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

/* rtl/dabd_row.sv */
`timescale 1ns / 1ps
`default_nettype none

module dabd_row #(
   parameter int unsigned MAX_CLASSES = dabd_pkg::DEF_MAX_CLASSES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            adv,
   input  wire logic                            accept,
   input  wire dabd_pkg::req_type               req,
   input  wire logic [dabd_pkg::NCLS_W-1:0]     num_classes,
   output logic                                 snap_vld_ff,
   output dabd_pkg::row_type                    snap_ff,
   output logic [dabd_pkg::VALUE_W-1:0]         thr_value
);

   import dabd_pkg::*;

   localparam int unsigned TBL_DEPTH = (MAX_CLASSES < 128) ? MAX_CLASSES : 128;
   localparam int unsigned ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

   logic [CNT_W-1:0]          count_ff, count_in;
   row_type                   row_ff, row_in;
   logic [TBL_DEPTH-1:0]      tvld_ff;
   logic [NCLS_W-1:0]         active;
   logic [CNT_W:0]            last;
   logic [CNT_W-1:0]          cnt;
   logic                      row_end;
   logic                      wr_hit;
   logic                      rd_en;
   logic [ADDR_W-1:0]         rd_addr;
   logic                      rd_in_range;
   logic [VALUE_W-1:0]        ram_q;

   // classes in use: zero counts as one, capped at table size
   always_comb begin
      if (num_classes == '0) begin
         active = NCLS_W'(1);
      end else if (num_classes > NCLS_W'(TBL_DEPTH)) begin
         active = NCLS_W'(TBL_DEPTH);
      end else begin
         active = num_classes;
      end
      last = {1'b0, active} + (CNT_W+1)'(3);
   end

   always_comb begin
      cnt    = req.first_of_tensor ? '0 : count_ff;
      row_in = row_ff;
      unique case (cnt)
         ATTR_CX: row_in.cx = req.value;
         ATTR_CY: row_in.cy = req.value;
         ATTR_W:  row_in.w  = req.value;
         ATTR_H:  row_in.h  = req.value;
         ATTR_SCORE: begin
            row_in.best = req.value;
            row_in.cls  = '0;
         end
         default: begin
            if ({1'b0, cnt} <= last && req.value > row_ff.best) begin
               row_in.best = req.value;
               row_in.cls  = CLASS_W'(cnt - ATTR_SCORE);
            end
         end
      endcase
      row_end  = ({1'b0, cnt} >= last);
      count_in = row_end ? '0 : cnt + CNT_W'(1);
      rd_in_range   = ({1'b0, row_in.cls} < (CLASS_W+1)'(TBL_DEPTH));
      rd_addr       = row_in.cls[ADDR_W-1:0];
      row_in.thr_en = rd_in_range && tvld_ff[rd_addr];
   end

   assign wr_hit = accept && (req.opcode == OP_THRESHOLD)
                   && ({1'b0, req.class_index} < (CLASS_W+1)'(TBL_DEPTH));
   assign rd_en  = accept && (req.opcode == OP_TENSOR) && row_end;

   // threshold table, entries never written are masked by per-entry valid bits
   dabd_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TBL_DEPTH)
   ) u_thr_ram (
      .clock    (clock),
      .we       (wr_hit),
      .waddr    (req.class_index[ADDR_W-1:0]),
      .wdata    (req.value),
      .re       (rd_en),
      .raddr    (rd_addr),
      .rdata_ff (ram_q)
   );

   assign thr_value = ram_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         row_ff      <= '0;
         tvld_ff     <= '0;
         snap_vld_ff <= 1'b0;
      end else begin
         if (wr_hit) begin
            tvld_ff[req.class_index[ADDR_W-1:0]] <= 1'b1;
         end
         if (accept && req.opcode == OP_TENSOR) begin
            count_ff <= count_in;
            row_ff   <= row_in;
         end
         if (adv) begin
            snap_vld_ff <= rd_en;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         snap_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/dabd_box.sv */
`timescale 1ns / 1ps
`default_nettype none

module dabd_box (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          snap_vld,
   input  wire dabd_pkg::row_type             snap,
   input  wire logic [dabd_pkg::VALUE_W-1:0]  thr_value,
   input  wire logic [dabd_pkg::FRAME_W-1:0]  frame_width,
   input  wire logic [dabd_pkg::FRAME_W-1:0]  frame_height,
   input  wire logic                          rsp_ready,
   output logic                               skid_vld_ff,
   output logic                               rsp_valid_ff,
   output dabd_pkg::rsp_type                  rsp_ff
);

   import dabd_pkg::*;

   logic               keep_b;
   logic               e_vld_ff;
   logic [COORD_W-1:0] x1_ff, x2_ff, y1_ff, y2_ff;
   logic [CLASS_W-1:0] cls_ff;
   logic [CONF_W-1:0]  conf_ff;
   logic [COORD_W-1:0] span_x, span_y;
   logic               keep_c;
   rsp_type            box_in;
   rsp_type            skid_ff;

   // score range, class threshold and positive size
   always_comb begin
      keep_b = snap_vld
               && !snap.best[VALUE_W-1] && (snap.best <= SCORE_ONE)
               && !(snap.thr_en && (snap.best < $signed(thr_value)))
               && (snap.w > 0) && (snap.h > 0);
   end

   always_comb begin
      span_x = x2_ff - x1_ff;
      span_y = y2_ff - y1_ff;
      keep_c = e_vld_ff && (span_x[COORD_W-1:16] != '0) && (span_y[COORD_W-1:16] != '0);
      box_in.box_left      = x1_ff;
      box_in.box_top       = y1_ff;
      box_in.box_span_x    = span_x;
      box_in.box_span_y    = span_y;
      box_in.best_class_id = cls_ff;
      box_in.confidence    = conf_ff;
   end

   // a box finished while the output word waits parks in the skid slot
   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= keep_b;
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_ff <= keep_c;
         end else if (keep_c) begin
            skid_vld_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         skid_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff   <= clamp_edge(snap.cx, snap.w, 1'b0, frame_width);
         x2_ff   <= clamp_edge(snap.cx, snap.w, 1'b1, frame_width);
         y1_ff   <= clamp_edge(snap.cy, snap.h, 1'b0, frame_height);
         y2_ff   <= clamp_edge(snap.cy, snap.h, 1'b1, frame_height);
         cls_ff  <= snap.cls;
         conf_ff <= snap.best[CONF_W-1:0];
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_ff <= box_in;
         end else begin
            skid_ff <= box_in;
         end
      end else if (rsp_ready) begin
         rsp_ff <= skid_ff;
      end
   end

endmodule

`default_nettype wire

/* rtl/detection_argmax_box_decoder_top.sv */
// detection box decoder: reads a row-major stream of q16.16 words (center x,
// center y, width, height, then one score per class) and emits one corner box
// per row that survives the score, threshold and size checks
// req channel: valid/ready; opcode selects a class threshold write or one
// tensor word; first_of_tensor restarts row counting on a tensor word
// rsp channel: valid/ready; one word per surviving row, none for dropped rows
// csr port: write enable, index, data; the user must write it only while the
// block is idle, the block itself does not enforce it; throughput: one req
// word per cycle while the skid slot is empty; the threshold ram has one write
// and one read port, so a threshold write and a row-end lookup never collide
// pipeline registers: snapshot and threshold read, edge clamp, span check
// reset: control and configuration registers take their defaults, row counting
// restarts and valid bits per entry turn every threshold off, no clearing pass
// stall: a rsp word that is not taken waits in the output register while the
// pipeline keeps running; the next box parks in a skid slot, req_ready drops
// the cycle after and rises again the cycle after the waiting word is taken
`timescale 1ns / 1ps
`default_nettype none

module detection_argmax_box_decoder_top #(
   parameter int unsigned MAX_CLASSES = dabd_pkg::DEF_MAX_CLASSES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request words
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire dabd_pkg::req_type                 req_data,
   // result words
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output dabd_pkg::rsp_type                      rsp_data,
   // register writes
   input  wire logic                              csr_we,
   input  wire logic [dabd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dabd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import dabd_pkg::*;

   logic [NCLS_W-1:0]  num_classes_ff;
   logic [FRAME_W-1:0] frame_width_ff;
   logic [FRAME_W-1:0] frame_height_ff;
   logic               adv;
   logic               accept;
   logic               snap_vld;
   row_type            snap;
   logic [VALUE_W-1:0] thr_value;
   logic               skid_full;

   // the pipeline only stops while the skid slot holds a box
   assign adv       = !skid_full;
   assign req_ready = adv;
   assign accept    = req_valid && req_ready;

   // configuration registers, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         num_classes_ff  <= RST_NUM_CLASSES;
         frame_width_ff  <= RST_FRAME_SIZE;
         frame_height_ff <= RST_FRAME_SIZE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_CLASSES:  num_classes_ff  <= csr_wdata[NCLS_W-1:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FRAME_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   // row tracking, running argmax and threshold table
   dabd_row #(
      .MAX_CLASSES (MAX_CLASSES)
   ) u_row (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .accept      (accept),
      .req         (req_data),
      .num_classes (num_classes_ff),
      .snap_vld_ff (snap_vld),
      .snap_ff     (snap),
      .thr_value   (thr_value)
   );

   // judgement, edge clamping, output register and skid slot
   dabd_box u_box (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .snap_vld     (snap_vld),
      .snap         (snap),
      .thr_value    (thr_value),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .rsp_ready    (rsp_ready),
      .skid_vld_ff  (skid_full),
      .rsp_valid_ff (rsp_valid),
      .rsp_ff       (rsp_data)
   );

endmodule

`default_nettype wire
